### src/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared constants and codes of the k-nearest-neighbor binary classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

	// Default sizing of the model store and the neighbor list.
	localparam int ModelDepth  = 512;
	localparam int MaxK        = 8;
	localparam int NumFeats    = 4;
	localparam int FeatureBits = 16;

	// Squared distances are kept to this many bits; an empty slot holds all ones.
	localparam int DistBits = 35;

	// Stream and register widths.
	localparam int InDataBits  = 72;
	localparam int OutDataBits = 8;
	localparam int KBits       = 4;
	localparam logic [KBits-1:0] KReset = 4'd3;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_QUERY  = 2'd1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLASSIFIED = 2'd0,
		ST_STORED     = 2'd1,
		ST_FULL       = 2'd2,
		ST_CLEARED    = 2'd3
	} status_t;

endpackage

### src/knn_binary_classifier.sv
// ----------------------------------------------------------------------------
// knn_binary_classifier
// k-nearest-neighbor binary classifier over a store of labeled feature words.
// ----------------------------------------------------------------------------
// Append and clear words give their result in the cycle after acceptance.
// A query walks the N stored entries: one multiplier squares one feature
// difference per cycle, and each entry is then merged into the sorted
// neighbor list; no new word is accepted until the query has voted.
// Reset is asynchronous: it empties the store count and sets k to 3; stored
// words are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module knn_binary_classifier #(
	parameter int MODEL_DEPTH  = knn_pkg::ModelDepth,
	parameter int MAX_K        = knn_pkg::MaxK,
	parameter int NUM_FEATS    = knn_pkg::NumFeats,
	parameter int FEATURE_BITS = knn_pkg::FeatureBits
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [knn_pkg::KBits-1:0]        cfg_wdata,   // k_neighbors
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// feature_a, feature_b, feature_c, feature_d, train_label, zero fill
	input  logic [knn_pkg::InDataBits-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,     // cmd
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// predicted_label, vote_sum, zero fill
	output logic [knn_pkg::OutDataBits-1:0]  m_tdata,
	output logic [1:0]                       m_tuser      // status
);

	import knn_pkg::*;

	localparam int FB     = FEATURE_BITS;
	localparam int CntW   = $clog2(MODEL_DEPTH + 1);
	localparam int AddrW  = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1;
	localparam int FIdxW  = (NUM_FEATS > 1) ? $clog2(NUM_FEATS) : 1;
	localparam int WordW  = NUM_FEATS * FB + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_INS,
		S_VOTE
	} state_t;

	state_t             state_q;
	logic [CntW-1:0]    cnt_q;
	logic [CntW-1:0]    rd_idx_q;
	logic [FIdxW-1:0]   f_q;
	logic [KBits-1:0]   k_q;
	logic               m_tvalid_q;
	status_t            m_tuser_q;
	logic               pred_q;
	logic [KBits-1:0]   votes_q;

	logic signed [FB-1:0] qf_q [NUM_FEATS];
	logic [KBits-1:0]     keff_q;
	logic [DistBits-1:0]  acc_q;
	logic [DistBits-1:0]  best_d_q [MAX_K];
	logic [MAX_K-1:0]     best_l_q;

	logic               in_acc;
	cmd_t               cmd;
	logic               full;
	logic               res_load;
	logic [KBits-1:0]   keff_in;
	logic               ram_we;
	logic [WordW-1:0]   ram_wdata;
	logic               ram_re;
	logic [AddrW-1:0]   ram_raddr;
	logic [WordW-1:0]   ram_rdata;
	logic [CntW-1:0]    next_idx;
	logic               more;
	logic signed [FB-1:0] mf [NUM_FEATS];
	logic               mem_label;
	logic signed [FB:0]     diff;
	logic signed [2*FB+1:0] prod;
	logic [2*FB-1:0]    sq;
	logic [MAX_K-1:0]   kmask;
	logic [MAX_K-1:0]   hit;
	logic [KBits-1:0]   votes;
	logic               pred;

	assign in_acc   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign full     = (cnt_q == CntW'(MODEL_DEPTH));
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign next_idx = rd_idx_q + CntW'(1);
	assign more     = (next_idx < cnt_q);

	// A result word is loaded by an append or clear, or when a query has voted.
	assign res_load = ((state_q == S_IDLE) && in_acc && (cmd != CMD_QUERY))
		|| ((state_q == S_VOTE) && (!m_tvalid_q || m_tready));

	// Out-of-range k is clamped into 1..MAX_K.
	always_comb begin
		if (k_q == '0) begin
			keff_in = KBits'(1);
		end else if (int'(k_q) > MAX_K) begin
			keff_in = KBits'(MAX_K);
		end else begin
			keff_in = k_q;
		end
	end

	// Only the low FEATURE_BITS of each feature are kept in the store.
	always_comb begin
		ram_wdata = '0;
		for (int f = 0; f < NUM_FEATS; f++) begin
			ram_wdata[f*FB +: FB] = s_tdata[16*f +: FB];
		end
		ram_wdata[NUM_FEATS*FB] = s_tdata[64];
	end

	assign ram_we = in_acc && (cmd == CMD_APPEND) && !full;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (state_q == S_IDLE) begin
			ram_re = in_acc && (cmd == CMD_QUERY);
		end else if (state_q == S_INS) begin
			ram_re    = more;
			ram_raddr = next_idx[AddrW-1:0];
		end
	end

	knn_ram #(
		.WIDTH(WordW),
		.DEPTH(MODEL_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AddrW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int f = 0; f < NUM_FEATS; f++) begin
			mf[f] = ram_rdata[f*FB +: FB];
		end
	end
	assign mem_label = ram_rdata[NUM_FEATS*FB];

	// Shared squaring unit: one feature difference per cycle.
	assign diff = {qf_q[f_q][FB-1], qf_q[f_q]} - {mf[f_q][FB-1], mf[f_q]};
	assign prod = diff * diff;
	assign sq   = prod[2*FB-1:0];

	// The list is sorted, so the hits form a contiguous run up to slot k-1.
	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			kmask[j] = (j < int'(keff_q));
			hit[j]   = kmask[j] && (acc_q <= best_d_q[j]);
		end
	end

	assign votes = KBits'($countones(best_l_q & kmask));
	assign pred  = ({1'b0, votes, 1'b0} > {2'b00, keff_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KReset;
		end else if (cfg_we) begin
			k_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			f_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= ST_CLASSIFIED;
			pred_q     <= 1'b0;
			votes_q    <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (cmd)
							CMD_APPEND: begin
								pred_q     <= 1'b0;
								votes_q    <= '0;
								if (!full) begin
									cnt_q     <= cnt_q + CntW'(1);
									m_tuser_q <= ST_STORED;
								end else begin
									m_tuser_q <= ST_FULL;
								end
							end
							CMD_QUERY: begin
								rd_idx_q <= '0;
								f_q      <= '0;
								state_q  <= (cnt_q == '0) ? S_VOTE : S_MAC;
							end
							default: begin
								// Clear, and the unused code as well.
								cnt_q      <= '0;
								m_tuser_q  <= ST_CLEARED;
								pred_q     <= 1'b0;
								votes_q    <= '0;
							end
						endcase
					end
				end
				S_MAC: begin
					if (f_q == FIdxW'(NUM_FEATS - 1)) begin
						f_q     <= '0;
						state_q <= S_INS;
					end else begin
						f_q <= f_q + FIdxW'(1);
					end
				end
				S_INS: begin
					if (more) begin
						rd_idx_q <= next_idx;
						state_q  <= S_MAC;
					end else begin
						state_q <= S_VOTE;
					end
				end
				S_VOTE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tuser_q  <= ST_CLASSIFIED;
						pred_q     <= pred;
						votes_q    <= votes;
						state_q    <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (cmd == CMD_QUERY)) begin
			for (int f = 0; f < NUM_FEATS; f++) begin
				qf_q[f] <= s_tdata[16*f +: FB];
			end
			keff_q <= keff_in;
			for (int j = 0; j < MAX_K; j++) begin
				best_d_q[j] <= '1;
			end
			best_l_q <= '0;
		end
		if (state_q == S_MAC) begin
			acc_q <= ((f_q == '0) ? '0 : acc_q) + DistBits'(sq);
		end
		if (state_q == S_INS) begin
			// A new entry goes ahead of an equal distance; the run behind it shifts.
			if (hit[0]) begin
				best_d_q[0] <= acc_q;
				best_l_q[0] <= mem_label;
			end
			for (int j = 1; j < MAX_K; j++) begin
				if (hit[j]) begin
					if (hit[j-1]) begin
						best_d_q[j] <= best_d_q[j-1];
						best_l_q[j] <= best_l_q[j-1];
					end else begin
						best_d_q[j] <= acc_q;
						best_l_q[j] <= mem_label;
					end
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = {3'b000, votes_q, pred_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MODEL_DEPTH))
		else $error("entry count above store depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (rd_idx_q < cnt_q))
		else $error("query reads beyond stored entries");

	a_votes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_CLASSIFIED)) |-> (m_tdata[4:1] <= keff_q))
		else $error("vote sum exceeds k");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q == S_VOTE) || $past(in_acc)))
		else $error("result word without a finished item");

endmodule

### src/knn_ram.sv
// ----------------------------------------------------------------------------
// knn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module knn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
